>>> hw/rtl/igm_pkg.sv
// Shared types and constants for the image gradient magnitude block.
package igm_pkg;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 4096;
    localparam int RootSteps  = 12;

    localparam logic [1:0] ModeForward  = 2'd0;
    localparam logic [1:0] ModeBackward = 2'd1;
    localparam logic [1:0] ModeCentral  = 2'd2;
    localparam logic [1:0] ModeSobel    = 2'd3;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgMode   = 2'd2;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic [11:0] mag;
        logic [11:0] gx;
        logic [11:0] gy;
        logic        border;
        logic        last;
    } t_result;
endpackage

>>> hw/rtl/igm_ram.sv
// Generic single-port synchronous RAM with registered read.
module igm_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> hw/rtl/igm_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module igm_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_value,
    output logic        o_busy,
    output logic        o_done,
    output logic [11:0] o_root
);
    logic [23:0] r_rem;
    logic [11:0] r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [13:0] trial;
    logic [4:0]  sh;
    logic [23:0] rem_hi;
    logic [23:0] rem_sub;
    logic        take;

    // compare (rem >> 2*cnt) against 4*root+1
    assign trial   = {r_root, 2'b01};
    assign sh      = {r_cnt, 1'b0};
    assign rem_hi  = r_rem >> sh;
    assign rem_sub = {10'd0, trial} << sh;
    assign take    = (rem_hi >= {10'd0, trial});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(igm_pkg::RootSteps - 1);
                r_rem  <= i_value;
                r_root <= '0;
            end else if (r_busy) begin
                if (take) begin
                    r_rem  <= r_rem - rem_sub;
                    r_root <= {r_root[10:0], 1'b1};
                end else begin
                    r_root <= {r_root[10:0], 1'b0};
                end
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
        end
    end
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> hw/rtl/image_gradient_magnitude.sv
// Top level: line stores, 3x3 window, gradient and magnitude sequencing.
//
// channel  dir  handshake              contents
// s_axis   in   s_axis_tvalid/tready   tdata[7:0] pixel, tuser frame_start
// m_axis   out  m_axis_tvalid/tready   tdata row,col,mag,gx,gy; tuser border; tlast
// cfg      in   i_cfg_we               i_cfg_index, i_cfg_wdata
//
// A pixel passes through accept, line store read, window update and classify, then
// its results leave while m_axis_tready is high; a pixel that completes an
// interior pixel adds the bit-serial square root (issue, start, 12 steps, done).
// Synchronous active-low reset clears counters and window and loads the default
// configuration (640x480, Sobel); other data registers and line stores are not
// cleared. A stalled output holds the sequencer; no pixel is taken until all its
// results have left.
module image_gradient_magnitude (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // row[11:0] col[21:12] mag[33:22] gx[45:34] gy[57:46]
    output logic        m_axis_tuser,   // [0] on_border
    output logic        m_axis_tlast
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_READ = 5'b00010, S_CALC = 5'b00100,
        S_ROOT = 5'b01000, S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    logic [10:0] r_w;
    logic [12:0] r_h;
    logic [1:0]  r_mode;
    logic [7:0]  r_win [9];
    logic [9:0]  r_col;
    logic [11:0] r_row;
    logic [9:0]  r_c;
    logic [11:0] r_r;
    logic [7:0]  r_px;
    logic        r_int, r_bor;
    logic        r_sq_start;
    logic signed [11:0] r_gx, r_gy;
    logic [23:0] r_e;
    logic        r_sent_int;

    logic [7:0] a_rd, b_rd;
    logic       mem_we;
    logic [12:0] w_cl, h_cl;

    assign w_cl = (r_w < 11'd3) ? 13'd3 : (r_w > 11'(igm_pkg::MaxWidth)) ?
                  13'(igm_pkg::MaxWidth) : {2'b00, r_w};
    assign h_cl = (r_h < 13'd3) ? 13'd3 : (r_h > 13'(igm_pkg::MaxHeight)) ?
                  13'(igm_pkg::MaxHeight) : r_h;
    // write back once the old entries have been read out
    assign mem_we = (r_state == S_CALC);

    igm_ram #(.Width(8), .Depth(igm_pkg::MaxWidth)) u_above (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(r_c), .i_wdata(r_px), .o_rdata(a_rd));
    igm_ram #(.Width(8), .Depth(igm_pkg::MaxWidth)) u_two (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(r_c), .i_wdata(a_rd), .o_rdata(b_rd));

    logic sq_busy, sq_done;
    logic [11:0] sq_root;
    igm_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_start),
        .i_value(r_e), .o_busy(sq_busy), .o_done(sq_done), .o_root(sq_root));

    logic signed [12:0] q [9];
    logic signed [12:0] gx_c, gy_c;
    always_comb begin
        for (int k = 0; k < 9; k++) q[k] = 13'(r_win[k]);
        // window already holds the new column when in S_ROOT
        unique case (r_mode)
            igm_pkg::ModeForward: begin
                gx_c = 13'((q[4] - q[5]) <<< 3);
                gy_c = 13'((q[4] - q[7]) <<< 3);
            end
            igm_pkg::ModeBackward: begin
                gx_c = 13'((q[4] - q[3]) <<< 3);
                gy_c = 13'((q[4] - q[1]) <<< 3);
            end
            igm_pkg::ModeCentral: begin
                gx_c = 13'((q[3] - q[5]) <<< 2);
                gy_c = 13'((q[1] - q[7]) <<< 2);
            end
            default: begin
                gx_c = (q[0] + (q[3] <<< 1) + q[6]) - (q[2] + (q[5] <<< 1) + q[8]);
                gy_c = (q[0] + (q[1] <<< 1) + q[2]) - (q[6] + (q[7] <<< 1) + q[8]);
            end
        endcase
    end

    logic signed [25:0] gx_sq, gy_sq;
    logic [25:0] e_sum;
    assign gx_sq = gx_c * gx_c;
    assign gy_sq = gy_c * gy_c;
    assign e_sum = gx_sq + gy_sq;

    logic [10:0] c_next;
    assign c_next = {1'b0, r_c} + 11'd1;

    logic show_int;
    assign show_int = r_int && r_sent_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w <= 11'd640; r_h <= 13'd480; r_mode <= igm_pkg::ModeSobel;
            r_col <= '0; r_row <= '0; r_sq_start <= 1'b0; r_sent_int <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            r_sq_start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    igm_pkg::CfgWidth:  r_w <= i_cfg_wdata[10:0];
                    igm_pkg::CfgHeight: r_h <= i_cfg_wdata;
                    igm_pkg::CfgMode:   r_mode <= i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_px <= s_axis_tdata;
                    r_c  <= s_axis_tuser ? 10'd0 : r_col;
                    r_r  <= s_axis_tuser ? 12'd0 : r_row;
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_CALC;
                S_CALC: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k*3]   <= r_win[k*3+1];
                        r_win[k*3+1] <= r_win[k*3+2];
                    end
                    r_win[2] <= b_rd; r_win[5] <= a_rd; r_win[8] <= r_px;
                    r_int <= (r_r >= 12'd2) && ({1'b0, r_r} <= h_cl - 13'd1)
                          && (r_c >= 10'd2) && ({3'b0, r_c} <= w_cl - 13'd1);
                    r_bor <= (r_r == 12'd0) || ({1'b0, r_r} >= h_cl - 13'd1)
                          || (r_c == 10'd0) || ({3'b0, r_c} >= w_cl - 13'd1);
                    r_sent_int <= 1'b0;
                    if ({2'b0, c_next} >= w_cl) begin
                        r_col <= '0;
                        r_row <= ({1'b0, r_r} + 13'd1 >= h_cl) ? 12'd0 : r_r + 12'd1;
                    end else begin
                        r_col <= c_next[9:0];
                        r_row <= r_r;
                    end
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (!r_int) r_state <= r_bor ? S_OUT : S_IDLE;
                    else if (!sq_busy && !sq_done && !r_sq_start && !r_sent_int) begin
                        r_gx <= gx_c[11:0]; r_gy <= gy_c[11:0];
                        r_e  <= e_sum[23:0];
                        r_sq_start <= 1'b1;
                        r_sent_int <= 1'b1;
                    end else if (sq_done) r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    if (show_int && r_bor) begin
                        // interior result left; border result of this pixel follows
                        r_int <= 1'b0;
                        r_sent_int <= 1'b0;
                    end else begin
                        r_int <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = !show_int;
    assign m_axis_tlast  = !(show_int && r_bor);
    assign m_axis_tdata  = show_int ?
        {6'd0, r_gy, r_gx, sq_root, r_c - 10'd1, r_r - 12'd1} :
        {6'd0, 12'd0, 12'd0, {1'b0, r_px, 3'b000}, r_c, r_r};
endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the image gradient magnitude block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int SettleCycles = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] pixel
    logic        s_axis_tuser;   // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // row, col, mag, gx, gy from bit 0 up
    logic        m_axis_tuser;   // [0] on_border
    logic        m_axis_tlast;

    image_gradient_magnitude uut (.*);

    // predictor state
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  line_above [igm_pkg::MaxWidth];
    logic [7:0]  line_two_above [igm_pkg::MaxWidth];
    logic [7:0]  win [9];
    int          col_pos;
    int          row_pos;

    igm_pkg::t_result pending_results[$];
    int          error_count;
    int          pixels_sent;
    int          hold_cycles;
    bit          no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[image_gradient_magnitude] ERROR");
        $finish;
    end

    function automatic int isqrt(int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic igm_pkg::t_result make_result(int r, int c, int mag, int gx, int gy,
                                                     bit brd);
        igm_pkg::t_result t;
        t.row = r[11:0];
        t.col = c[9:0];
        t.mag = mag[11:0];
        t.gx = gx[11:0];
        t.gy = gy[11:0];
        t.border = brd;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void predict_pixel(logic [7:0] px, logic fs);
        int w, h, r, c, gx, gy, n;
        int q [9];
        igm_pkg::t_result res [2];
        w = width_reg;
        h = height_reg;
        n = 0;
        if (w < 3) w = 3;
        if (w > igm_pkg::MaxWidth) w = igm_pkg::MaxWidth;
        if (h < 3) h = 3;
        if (h > igm_pkg::MaxHeight) h = igm_pkg::MaxHeight;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = line_two_above[c];
        win[5] = line_above[c];
        win[8] = px;
        line_two_above[c] = line_above[c];
        line_above[c] = px;
        for (int i = 0; i < 9; i++) q[i] = win[i];
        if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
            case (mode_reg)
                igm_pkg::ModeForward: begin
                    gx = 8 * (q[4] - q[5]);
                    gy = 8 * (q[4] - q[7]);
                end
                igm_pkg::ModeBackward: begin
                    gx = 8 * (q[4] - q[3]);
                    gy = 8 * (q[4] - q[1]);
                end
                igm_pkg::ModeCentral: begin
                    gx = 4 * (q[3] - q[5]);
                    gy = 4 * (q[1] - q[7]);
                end
                default: begin
                    gx = (q[0] + 2 * q[3] + q[6]) - (q[2] + 2 * q[5] + q[8]);
                    gy = (q[0] + 2 * q[1] + q[2]) - (q[6] + 2 * q[7] + q[8]);
                end
            endcase
            res[n] = make_result(r - 1, c - 1, isqrt(gx * gx + gy * gy), gx, gy, 1'b0);
            n++;
        end
        if (r == 0 || r >= h - 1 || c == 0 || c >= w - 1) begin
            res[n] = make_result(r, c, px * 8, 0, 0, 1'b1);
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (no_gaps || k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] pick_pixel();
        int k;
        k = $urandom_range(0, 9);
        if (k < 2) return 8'd0;
        if (k < 4) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one pixel, hold until accepted, then idle for a random gap
    task automatic send_pixel(logic [7:0] px, logic fs);
        int g;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = px;
        s_axis_tuser = fs;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(px, fs);
        pixels_sent++;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata = 8'($urandom_range(0, 255));
            s_axis_tuser = 1'($urandom_range(0, 1));
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value[12:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            igm_pkg::CfgWidth:  width_reg = value[10:0];
            igm_pkg::CfgHeight: height_reg = value[12:0];
            igm_pkg::CfgMode:   mode_reg = value[1:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(int w, int h, bit with_start);
        for (int i = 0; i < w * h; i++) send_pixel(pick_pixel(), with_start && i == 0);
    endtask

    // one small frame per mode with saturated content
    task automatic test_modes_extremes();
        logic [1:0] m;
        write_reg(igm_pkg::CfgWidth, 3);
        write_reg(igm_pkg::CfgHeight, 3);
        for (int k = 0; k < 4; k++) begin
            m = 2'(k);
            write_reg(igm_pkg::CfgMode, m);
            for (int i = 0; i < 9; i++)
                send_pixel(((i + k) % 2) ? 8'd255 : 8'd0, i == 0);
            drain();
        end
        write_reg(CfgUnused, 13'h1fff);
    endtask

    // out-of-range sizes are clamped; height shrink mid-frame turns rows into border
    task automatic test_clamps();
        write_reg(igm_pkg::CfgWidth, 0);
        write_reg(igm_pkg::CfgHeight, 1);
        send_frame(3, 3, 1'b1);
        drain();
        write_reg(igm_pkg::CfgWidth, 2047);
        write_reg(igm_pkg::CfgHeight, 8191);
        for (int i = 0; i < 5; i++) send_pixel(pick_pixel(), i == 0);
        drain();
        write_reg(igm_pkg::CfgWidth, 5);
        write_reg(igm_pkg::CfgHeight, 4096);
        send_frame(5, 4, 1'b1);
        drain();
        write_reg(igm_pkg::CfgHeight, 3);
        send_frame(5, 2, 1'b0);
        drain();
        write_reg(igm_pkg::CfgWidth, 4);
        for (int i = 0; i < 8; i++) send_pixel(pick_pixel(), 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(igm_pkg::CfgWidth, 6);
        write_reg(igm_pkg::CfgHeight, 5);
        hold_cycles = 300;
        no_gaps = 1'b1;
        send_frame(6, 5, 1'b1);
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random_frames();
        int w, h, stop_at, target;
        target = pixels_sent + 180;
        while (pixels_sent < target) begin
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            write_reg(igm_pkg::CfgWidth, w);
            write_reg(igm_pkg::CfgHeight, h);
            write_reg(igm_pkg::CfgMode, $urandom_range(0, 3));
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
            for (int i = 0; i < stop_at; i++)
                send_pixel(pick_pixel(), i == 0 || $urandom_range(0, 49) == 0);
            // complete frame may roll straight into the next one
            if (stop_at == w * h && $urandom_range(0, 2) == 0) send_frame(w, h, 1'b0);
            drain();
        end
    endtask

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge i_clk) begin
        igm_pkg::t_result got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.row = m_axis_tdata[11:0];
            got.col = m_axis_tdata[21:12];
            got.mag = m_axis_tdata[33:22];
            got.gx = m_axis_tdata[45:34];
            got.gy = m_axis_tdata[57:46];
            got.border = m_axis_tuser;
            got.last = m_axis_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction: row %0d col %0d", $time, got.row, got.col);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t mismatch exp row %0d col %0d mag %0d gx %0d gy %0d b %0b l %0b",
                             $time, exp_r.row, exp_r.col, exp_r.mag, $signed(exp_r.gx),
                             $signed(exp_r.gy), exp_r.border, exp_r.last);
                    $display("%0t          act row %0d col %0d mag %0d gx %0d gy %0d b %0b l %0b",
                             $time, got.row, got.col, got.mag, $signed(got.gx),
                             $signed(got.gy), got.border, got.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = igm_pkg::CfgWidth;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        width_reg = 11'd640;
        height_reg = 13'd480;
        mode_reg = igm_pkg::ModeSobel;
        foreach (win[i]) win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        error_count = 0;
        pixels_sent = 0;
        hold_cycles = 0;
        no_gaps = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_modes_extremes();
        test_clamps();
        test_backpressure();
        test_random_frames();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[image_gradient_magnitude] OK");
        end else begin
            $display("[image_gradient_magnitude] ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/igm_pkg.sv
hw/rtl/igm_ram.sv
hw/rtl/igm_sqrt.sv
hw/rtl/image_gradient_magnitude.sv
sim/tb_top.sv
